// ----- sv/beacon_parse_ap_table_defines.svh -----
// Assertion macros shared by the beacon parser RTL.
`ifndef BEACON_PARSE_AP_TABLE_DEFINES_SVH
`define BEACON_PARSE_AP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("beacon parser assertion failed");

// Next-cycle implication, disabled during reset.
`define BPAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("beacon parser assertion failed");

`endif

// ----- sv/bpat_pkg.sv -----
// Package with shared constants and types of the beacon parser.
package bpat_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int FILL_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] AUTH_OPEN = 3'd0;
   localparam logic [2:0] AUTH_WEP  = 3'd1;
   localparam logic [2:0] AUTH_WPA  = 3'd2;
   localparam logic [2:0] AUTH_WPA2 = 3'd3;
   localparam logic [2:0] AUTH_WPA3 = 3'd4;

   localparam logic [1:0] ST_IGNORED = 2'd0;
   localparam logic [1:0] ST_SUBTYPE = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_RECORD  = 2'd3;

   localparam logic [1:0] WALK_ID   = 2'd0;
   localparam logic [1:0] WALK_LEN  = 2'd1;
   localparam logic [1:0] WALK_BODY = 2'd2;
   localparam logic [1:0] WALK_DONE = 2'd3;

   localparam logic [7:0] EID_RSN    = 8'd48;
   localparam logic [7:0] EID_VENDOR = 8'd221;

   // Search token handed from one table cell to the next.
   typedef struct packed {
      logic             tok;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } link_type;

   // Frame summary produced by the byte parser on the closing beat.
   typedef struct packed {
      logic [3:0]  subtype;
      logic [47:0] bssid;
      logic [2:0]  auth;
   } frame_type;

endpackage

// ----- sv/bpat_parser.sv -----
// Per-byte frame parser: subtype, BSSID, privacy bit and tagged element walk.
module bpat_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat,
   input  logic                last,
   input  logic [7:0]          data_byte,
   input  logic [11:0]         frame_length,
   output bpat_pkg::frame_type frame
);

   logic [11:0] pos_ff, pos_in;
   logic [3:0]  sub_ff, sub_in, sub_n;
   logic [47:0] bssid_ff, bssid_in, bssid_n;
   logic [2:0]  auth_ff, auth_in, auth_n;
   logic [1:0]  phase_ff, phase_in, phase_n;
   logic [7:0]  id_ff, id_in, id_n;
   logic [7:0]  len_ff, len_in, len_n;
   logic [7:0]  k_ff, k_in, k_n;
   logic [31:0] sw_ff, sw_in, sw_n;
   logic [12:0] pos_p5;
   logic [12:0] flen13;

   assign pos_p5 = {1'b0, pos_ff} + 13'd5;
   assign flen13 = {1'b0, frame_length};

   always_comb begin
      sub_n = sub_ff;
      bssid_n = bssid_ff;
      auth_n = auth_ff;
      phase_n = phase_ff;
      id_n = id_ff;
      len_n = len_ff;
      k_n = k_ff;
      sw_n = sw_ff;
      if (pos_ff == 12'd0) begin
         sub_n = data_byte[7:4];
      end
      if (pos_ff >= 12'd16 && pos_ff <= 12'd21) begin
         bssid_n = {bssid_ff[39:0], data_byte};
      end
      if (pos_ff == 12'd34 && data_byte[4]) begin
         auth_n = bpat_pkg::AUTH_WEP;
      end
      if (pos_ff >= 12'd36) begin
         unique case (phase_ff)
            bpat_pkg::WALK_ID: begin
               if (pos_p5 < flen13) begin
                  id_n = data_byte;
                  phase_n = bpat_pkg::WALK_LEN;
               end else begin
                  phase_n = bpat_pkg::WALK_DONE;
               end
            end
            bpat_pkg::WALK_LEN: begin
               len_n = data_byte;
               if (pos_p5 + {5'd0, data_byte} > flen13) begin
                  phase_n = bpat_pkg::WALK_DONE;
               end else begin
                  if (id_ff == bpat_pkg::EID_RSN) begin
                     auth_n = bpat_pkg::AUTH_WPA2;
                  end
                  sw_n = 32'd0;
                  k_n = 8'd0;
                  phase_n = (data_byte != 8'd0) ? bpat_pkg::WALK_BODY : bpat_pkg::WALK_ID;
               end
            end
            bpat_pkg::WALK_BODY: begin
               sw_n = {sw_ff[23:0], data_byte};
               if (id_ff == bpat_pkg::EID_RSN && k_ff >= 8'd3 && sw_n == 32'h000F_AC08) begin
                  auth_n = bpat_pkg::AUTH_WPA3;
               end
               if (id_ff == bpat_pkg::EID_VENDOR && len_ff >= 8'd4 && k_ff == 8'd1 &&
                   sw_n[15:0] == 16'h0050 && auth_ff != bpat_pkg::AUTH_WPA2 &&
                   auth_ff != bpat_pkg::AUTH_WPA3) begin
                  auth_n = bpat_pkg::AUTH_WPA;
               end
               k_n = k_ff + 8'd1;
               if (k_n == len_ff) begin
                  phase_n = bpat_pkg::WALK_ID;
               end
            end
            default: begin
               phase_n = bpat_pkg::WALK_DONE;
            end
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      sub_in = sub_ff;
      bssid_in = bssid_ff;
      auth_in = auth_ff;
      phase_in = phase_ff;
      id_in = id_ff;
      len_in = len_ff;
      k_in = k_ff;
      sw_in = sw_ff;
      if (beat && last) begin
         pos_in = 12'd0;
         sub_in = 4'd0;
         bssid_in = 48'd0;
         auth_in = bpat_pkg::AUTH_OPEN;
         phase_in = bpat_pkg::WALK_ID;
         id_in = 8'd0;
         len_in = 8'd0;
         k_in = 8'd0;
         sw_in = 32'd0;
      end else if (beat) begin
         pos_in = (pos_ff == 12'hFFF) ? pos_ff : pos_ff + 12'd1;
         sub_in = sub_n;
         bssid_in = bssid_n;
         auth_in = auth_n;
         phase_in = phase_n;
         id_in = id_n;
         len_in = len_n;
         k_in = k_n;
         sw_in = sw_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 12'd0;
         sub_ff <= 4'd0;
         bssid_ff <= 48'd0;
         auth_ff <= bpat_pkg::AUTH_OPEN;
         phase_ff <= bpat_pkg::WALK_ID;
         id_ff <= 8'd0;
         len_ff <= 8'd0;
         k_ff <= 8'd0;
         sw_ff <= 32'd0;
      end else begin
         pos_ff <= pos_in;
         sub_ff <= sub_in;
         bssid_ff <= bssid_in;
         auth_ff <= auth_in;
         phase_ff <= phase_in;
         id_ff <= id_in;
         len_ff <= len_in;
         k_ff <= k_in;
         sw_ff <= sw_in;
      end
   end

   assign frame.subtype = sub_n;
   assign frame.bssid = bssid_n;
   assign frame.auth = auth_n;

endmodule

// ----- sv/bpat_cell.sv -----
// One table cell: holds a BSSID and checks the passing search token against it.
module bpat_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [bpat_pkg::IDX_W-1:0]            cell_index,
   input  logic [bpat_pkg::FILL_W-1:0]           fill,
   input  logic [47:0]                           query,
   input  logic                                  wr_en,
   input  logic [bpat_pkg::IDX_W-1:0]            wr_idx,
   input  logic [47:0]                           wr_bssid,
   input  bpat_pkg::link_type                    link_in,
   output bpat_pkg::link_type                    link_out
);

   logic [47:0]        bssid_ff;
   bpat_pkg::link_type link_ff, link_in_c;
   logic               match;

   assign match = link_in.tok && !link_in.hit &&
                  ({{(bpat_pkg::FILL_W - bpat_pkg::IDX_W){1'b0}}, cell_index} < fill) &&
                  (bssid_ff == query);

   always_comb begin
      link_in_c = link_in;
      if (match) begin
         link_in_c.hit = 1'b1;
         link_in_c.idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_idx == cell_index) begin
         bssid_ff <= wr_bssid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;

endmodule

// ----- sv/beacon_parse_ap_table.sv -----
// Top level of the beacon and probe-response parser with its access point table.
//
// Usage: frame bytes enter on the req_ stream, one byte per beat, with
// req_tlast on the final byte and the frame side data (length, RSSI,
// channel, GPS fix, time) carried with every beat. Between frames req_tready
// stays high, so non-final bytes are not stalled. On the final byte the block
// answers with exactly one beat on the rsp_ stream carrying the status and
// the table counters. Frames that are short, not management or of the wrong
// subtype answer in the cycle after the final byte. Qualifying frames send a
// search token down a row of MAX_ENTRIES table cells, one cell per cycle; a
// recorded frame then passes the S_READ and S_UPD states before it answers,
// while a frame dropped on a full table answers straight from S_SEARCH; the
// length of that cell chain sets the time per frame. While a frame is being
// searched or its answer waits, req_tready is low, so a stalled receiver
// holds off the next frame and the answer beat stays unchanged until it is taken.
// Reset clears the byte parser, the table fill and the beacon counter;
// table entries above the fill are never read, so no clearing pass runs.
module beacon_parse_ap_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_byte[7:0], frame_length[19:8], signal_dbm[27:20], hop_channel[31:28],
   // fix_valid[32], latitude[63:33], longitude[95:64], altitude_dm[116:96],
   // time_ms[148:117], zero fill above.
   input  logic [151:0] req_tdata,
   input  logic         req_tlast,
   // is_management.
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], entry_index[9:2], is_new[10], auth_code[13:11],
   // best_updated[14], notable_new[15], beacon_total[47:16],
   // entry_count[56:48], zero fill above.
   output logic [63:0]  rsp_tdata
);

   `include "beacon_parse_ap_table_defines.svh"

   localparam int N  = bpat_pkg::MAX_ENTRIES;
   localparam int IW = bpat_pkg::IDX_W;
   localparam int FW = bpat_pkg::FILL_W;

   localparam logic [2:0] S_BYTES  = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_UPD    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;

   // Request fields.
   logic [7:0]  in_byte;
   logic [11:0] in_flen;
   logic        beat;

   assign in_byte = req_tdata[7:0];
   assign in_flen = req_tdata[19:8];
   assign beat = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_BYTES);

   bpat_pkg::frame_type frame;

   bpat_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .last         (req_tlast),
      .data_byte    (in_byte),
      .frame_length (in_flen),
      .frame        (frame)
   );

   // Side data latched from the closing beat.
   logic [47:0] query_ff;
   logic [2:0]  auth_ff;
   logic [7:0]  sig_ff;
   logic [3:0]  chan_ff;
   logic        fix_ff;
   logic [63:0] posn_ff;
   logic [20:0] alt_ff;
   logic [31:0] time_ff;

   always_ff @(posedge clock) begin
      if (beat && req_tlast) begin
         query_ff <= frame.bssid;
         auth_ff <= frame.auth;
         sig_ff <= req_tdata[27:20];
         chan_ff <= req_tdata[31:28];
         fix_ff <= req_tdata[32];
         posn_ff <= {req_tdata[95:64], 1'b0, req_tdata[63:33]};
         alt_ff <= req_tdata[116:96];
         time_ff <= req_tdata[148:117];
      end
   end

   // Cell chain. The token enters cell 0 and leaves the last cell.
   bpat_pkg::link_type links [0:N];
   logic               wr_en;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [IW-1:0]      idx_ff, idx_in;

   assign links[0].tok = (state_ff == S_START);
   assign links[0].hit = 1'b0;
   assign links[0].idx = '0;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         bpat_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IW'(g)),
            .fill       (fill_ff),
            .query      (query_ff),
            .wr_en      (wr_en),
            .wr_idx     (idx_ff),
            .wr_bssid   (query_ff),
            .link_in    (links[g]),
            .link_out   (links[g+1])
         );
      end
   endgenerate

   // Per-entry attribute memories, addressed by the resolved slot.
   logic [7:0]  ap_rssi       [0:N-1];
   logic [3:0]  ap_channel    [0:N-1];
   logic [2:0]  ap_auth       [0:N-1];
   logic [63:0] ap_position   [0:N-1];
   logic [20:0] ap_altitude   [0:N-1];
   logic [31:0] ap_first_seen [0:N-1];
   logic [31:0] ap_last_seen  [0:N-1];
   logic        ap_dirty      [0:N-1];
   logic [7:0]  rssi_rd_ff;

   logic        new_ff, new_in;
   logic        best;
   logic [7:0]  old_rssi;

   assign old_rssi = new_ff ? 8'd0 : rssi_rd_ff;
   assign best = ($signed(sig_ff) > $signed(old_rssi)) || (old_rssi == 8'd0);
   assign wr_en = (state_ff == S_UPD) && new_ff;

   always_ff @(posedge clock) begin
      rssi_rd_ff <= ap_rssi[idx_ff];
      if (state_ff == S_UPD) begin
         ap_last_seen[idx_ff] <= time_ff;
         ap_channel[idx_ff] <= chan_ff;
         ap_auth[idx_ff] <= auth_ff;
         if (new_ff) begin
            ap_first_seen[idx_ff] <= time_ff;
         end
         if (best) begin
            ap_rssi[idx_ff] <= sig_ff;
            ap_dirty[idx_ff] <= 1'b1;
         end else if (new_ff) begin
            ap_rssi[idx_ff] <= 8'd0;
            ap_dirty[idx_ff] <= 1'b0;
         end
         if (best && fix_ff) begin
            ap_position[idx_ff] <= posn_ff;
            ap_altitude[idx_ff] <= alt_ff;
         end else if (new_ff) begin
            ap_position[idx_ff] <= 64'd0;
            ap_altitude[idx_ff] <= 21'd0;
         end
      end
   end

   // Control sequencer and result register.
   logic [31:0] total_ff, total_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  oauth_ff, oauth_in;
   logic [7:0]  oidx_ff, oidx_in;
   logic        onew_ff, onew_in;
   logic        obest_ff, obest_in;
   logic        onot_ff, onot_in;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      new_in = new_ff;
      status_in = status_ff;
      oauth_in = oauth_ff;
      oidx_in = oidx_ff;
      onew_in = onew_ff;
      obest_in = obest_ff;
      onot_in = onot_ff;
      unique case (state_ff)
         S_BYTES: begin
            if (beat && req_tlast) begin
               status_in = bpat_pkg::ST_IGNORED;
               oauth_in = bpat_pkg::AUTH_OPEN;
               oidx_in = 8'd0;
               onew_in = 1'b0;
               obest_in = 1'b0;
               onot_in = 1'b0;
               if (!req_tuser || in_flen < 12'd36) begin
                  state_in = S_OUT;
               end else if (frame.subtype != 4'h8 && frame.subtype != 4'h5) begin
                  status_in = bpat_pkg::ST_SUBTYPE;
                  state_in = S_OUT;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (links[N].tok) begin
               if (links[N].hit) begin
                  idx_in = links[N].idx;
                  new_in = 1'b0;
                  state_in = S_READ;
               end else if (fill_ff >= FW'(N)) begin
                  status_in = bpat_pkg::ST_FULL;
                  state_in = S_OUT;
               end else begin
                  idx_in = IW'(fill_ff);
                  new_in = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (new_ff) begin
               fill_in = fill_ff + FW'(1);
            end
            total_in = total_ff + 32'd1;
            status_in = bpat_pkg::ST_RECORD;
            oidx_in = 8'(idx_ff);
            onew_in = new_ff;
            oauth_in = auth_ff;
            obest_in = best;
            onot_in = new_ff && (auth_ff == bpat_pkg::AUTH_OPEN ||
                                 auth_ff == bpat_pkg::AUTH_WPA3);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_BYTES;
            end
         end
         default: begin
            state_in = S_BYTES;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BYTES;
         fill_ff <= '0;
         total_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      new_ff <= new_in;
      status_ff <= status_in;
      oauth_ff <= oauth_in;
      oidx_ff <= oidx_in;
      onew_ff <= onew_in;
      obest_ff <= obest_in;
      onot_ff <= onot_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {7'd0, 9'(fill_ff), total_ff, onot_ff, obest_ff, oauth_ff,
                       onew_ff, oidx_ff, status_ff};

   // The fill never passes the table size.
   `BPAT_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(N))
   // A search token only leaves the chain while the sequencer waits for it.
   `BPAT_ASSERT_NOW(a_token_window, clock, reset, links[N].tok, state_ff == S_SEARCH)
   // Frames that are not recorded carry no slot, auth or flags.
   `BPAT_ASSERT_NOW(a_unrecorded_clean, clock, reset,
                    rsp_tvalid && status_ff != bpat_pkg::ST_RECORD,
                    rsp_tdata[15:2] == 14'd0)
   // A recorded frame always advances the beacon counter by one.
   `BPAT_ASSERT_NEXT(a_count_step, clock, reset, state_ff == S_UPD,
                     total_ff == $past(total_ff) + 32'd1)

endmodule

// ----- sim/tb_beacon_parse_ap_table.sv -----
// Self-checking testbench for the beacon parser and its access point table.
module tb_beacon_parse_ap_table;

   // One input beat: a frame byte together with the side data that rides along.
   typedef struct {
      logic [7:0]         data_byte;
      logic               last;
      logic               mgmt;
      logic [11:0]        flen;
      logic signed [7:0]  sig;
      logic [3:0]         chan;
      logic               fix;
      logic [30:0]        lat;
      logic [31:0]        lon;
      logic [20:0]        alt;
      logic [31:0]        tms;
   } frame_beat_type;

   // The answer that the block gives on the closing byte of a frame.
   typedef struct {
      logic [1:0]  status;
      logic [7:0]  slot;
      logic        is_new;
      logic [2:0]  auth;
      logic        best;
      logic        notable;
      logic [31:0] total;
      logic [8:0]  count;
   } frame_summary_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [151:0] req_tdata;
   logic         req_tlast;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;

   beacon_parse_ap_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted answers, oldest first, waiting for the matching result beat.
   frame_summary_type expected_summaries[$];
   int                error_count = 0;
   int                bytes_sent = 0;

   // Idle percentages for each side, and a pending receiver hold-off in cycles.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_hold_left = 0;

   // Mirror of the access point table. Only the BSSID and the RSSI are
   // visible at the outputs, so the rest of each entry is not kept.
   logic [47:0]        ap_mac[bpat_pkg::MAX_ENTRIES];
   logic signed [7:0]  ap_signal[bpat_pkg::MAX_ENTRIES];
   int                 ap_fill = 0;
   logic [31:0]        recorded_total = '0;

   // Per-frame parse state, cleared after every closing byte.
   int          cur_pos = 0;
   logic [47:0] cur_bssid = '0;
   logic [3:0]  cur_subtype = '0;
   logic [1:0]  el_phase = bpat_pkg::WALK_ID;
   logic [7:0]  el_id = '0;
   logic [7:0]  el_len = '0;
   int          el_k = 0;
   logic [31:0] suite_bytes = '0;
   logic [2:0]  cur_auth = bpat_pkg::AUTH_OPEN;

   // Bytes of the frame under construction, and a pool of reused BSSIDs so
   // that most beacons hit entries that already exist.
   logic [7:0]  frame_bytes[$];
   logic [47:0] mac_pool[48];
   logic [47:0] fresh_mac = 48'hA2_00_00_00_00_00;

   // The clock runs with a period of 12 time units.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Hard limit on the run, far above the slowest correct run.
   initial begin
      #(12 * 3000000);
      $display("FAIL");
      $finish;
   end

   // The receiver stalls at random, or for a whole stretch when a test asks.
   always @(negedge clock) begin
      if (recv_hold_left > 0) begin
         rsp_tready <= 1'b0;
         recv_hold_left = recv_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Each result beat is checked field by field against the oldest prediction.
   always @(posedge clock) begin
      frame_summary_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_summaries.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_tdata, '0);
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[9:2] !== want.slot)
               report_mismatch("entry_index", rsp_tdata[9:2], want.slot);
            if (rsp_tdata[10] !== want.is_new)
               report_mismatch("is_new", rsp_tdata[10], want.is_new);
            if (rsp_tdata[13:11] !== want.auth)
               report_mismatch("auth_code", rsp_tdata[13:11], want.auth);
            if (rsp_tdata[14] !== want.best)
               report_mismatch("best_updated", rsp_tdata[14], want.best);
            if (rsp_tdata[15] !== want.notable)
               report_mismatch("notable_new", rsp_tdata[15], want.notable);
            if (rsp_tdata[47:16] !== want.total)
               report_mismatch("beacon_total", rsp_tdata[47:16], want.total);
            if (rsp_tdata[56:48] !== want.count)
               report_mismatch("entry_count", rsp_tdata[56:48], want.count);
         end
      end
   end

   // One step of the tagged element walk. The region ends tag_len bytes past
   // byte 36; an element that does not fit stops the walk for the frame.
   task automatic walk_element_byte(input int off, input int tag_len, input logic [7:0] b);
      if (el_phase == bpat_pkg::WALK_ID) begin
         if (off + 1 < tag_len) begin
            el_id = b;
            el_phase = bpat_pkg::WALK_LEN;
         end else begin
            el_phase = bpat_pkg::WALK_DONE;
         end
      end else if (el_phase == bpat_pkg::WALK_LEN) begin
         el_len = b;
         if (off + 1 + int'(b) > tag_len) begin
            el_phase = bpat_pkg::WALK_DONE;
         end else begin
            if (el_id == bpat_pkg::EID_RSN) cur_auth = bpat_pkg::AUTH_WPA2;
            suite_bytes = '0;
            el_k = 0;
            el_phase = (b != 0) ? bpat_pkg::WALK_BODY : bpat_pkg::WALK_ID;
         end
      end else if (el_phase == bpat_pkg::WALK_BODY) begin
         suite_bytes = {suite_bytes[23:0], b};
         // An RSN body carrying the SAE suite marks WPA3.
         if (el_id == bpat_pkg::EID_RSN && el_k >= 3 && suite_bytes == 32'h000F_AC08)
            cur_auth = bpat_pkg::AUTH_WPA3;
         // A vendor body starting 00-50 marks WPA, unless RSN already ruled.
         if (el_id == bpat_pkg::EID_VENDOR && el_len >= 4 && el_k == 1 &&
             suite_bytes[15:0] == 16'h0050 &&
             cur_auth != bpat_pkg::AUTH_WPA2 && cur_auth != bpat_pkg::AUTH_WPA3)
            cur_auth = bpat_pkg::AUTH_WPA;
         el_k++;
         if (el_k == int'(el_len)) el_phase = bpat_pkg::WALK_ID;
      end
   endtask

   // Predicts the block for one accepted beat and queues the answer that a
   // closing byte causes.
   task automatic parse_frame_byte(input frame_beat_type bt);
      frame_summary_type s;
      int idx;
      logic signed [7:0] old;
      if (cur_pos == 0) cur_subtype = bt.data_byte[7:4];
      if (cur_pos >= 16 && cur_pos <= 21) cur_bssid = {cur_bssid[39:0], bt.data_byte};
      if (cur_pos == 34 && bt.data_byte[4]) cur_auth = bpat_pkg::AUTH_WEP;
      if (cur_pos >= 36) walk_element_byte(cur_pos - 36, int'(bt.flen) - 40, bt.data_byte);
      if (cur_pos < 4095) cur_pos++;
      if (!bt.last) return;

      s = '{default: '0};
      if (!bt.mgmt || bt.flen < 36) begin
         s.status = bpat_pkg::ST_IGNORED;
      end else if (cur_subtype != 4'h8 && cur_subtype != 4'h5) begin
         s.status = bpat_pkg::ST_SUBTYPE;
      end else begin
         idx = ap_fill;
         for (int i = 0; i < ap_fill; i++) begin
            if (ap_mac[i] == cur_bssid) begin
               idx = i;
               break;
            end
         end
         if (idx >= ap_fill && ap_fill >= bpat_pkg::MAX_ENTRIES) begin
            s.status = bpat_pkg::ST_FULL;
         end else begin
            if (idx >= ap_fill) begin
               idx = ap_fill;
               ap_fill++;
               s.is_new = 1'b1;
               ap_mac[idx] = cur_bssid;
               ap_signal[idx] = '0;
            end
            recorded_total++;
            s.notable = s.is_new && (cur_auth == bpat_pkg::AUTH_OPEN ||
                                     cur_auth == bpat_pkg::AUTH_WPA3);
            old = ap_signal[idx];
            if (bt.sig > old || old == 0) begin
               ap_signal[idx] = bt.sig;
               s.best = 1'b1;
            end
            s.status = bpat_pkg::ST_RECORD;
            s.slot = idx[7:0];
            s.auth = cur_auth;
         end
      end
      s.total = recorded_total;
      s.count = ap_fill[8:0];
      expected_summaries.push_back(s);

      cur_pos = 0;
      cur_bssid = '0;
      cur_subtype = '0;
      el_phase = bpat_pkg::WALK_ID;
      el_id = '0;
      el_len = '0;
      el_k = 0;
      suite_bytes = '0;
      cur_auth = bpat_pkg::AUTH_OPEN;
   endtask

   // Offers one beat, with random idle cycles ahead of it, and predicts it
   // once it is accepted. Inputs change only at the falling edge.
   task automatic send_beat(input frame_beat_type bt);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tdata  <= {3'b000, bt.tms, bt.alt, bt.lon, bt.lat, bt.fix, bt.chan, bt.sig,
                     bt.flen, bt.data_byte};
      req_tlast  <= bt.last;
      req_tuser  <= bt.mgmt;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      parse_frame_byte(bt);
      bytes_sent++;
   endtask

   // Sends the bytes in frame_bytes as one frame. Side data on the closing
   // beat is chosen here, with the extremes now and then; earlier beats carry
   // random side data, which the block must ignore apart from the length.
   task automatic send_frame(input int flen_val, input bit mgmt, input bit flen_noise);
      frame_beat_type bt;
      bit edge_vals;
      edge_vals = ($urandom_range(7) == 0);
      for (int i = 0; i < frame_bytes.size(); i++) begin
         bt.data_byte = frame_bytes[i];
         bt.last = (i == frame_bytes.size() - 1);
         bt.flen = flen_noise ? 12'($urandom) : 12'(flen_val);
         if (bt.last) begin
            bt.mgmt = mgmt;
            bt.fix  = $urandom_range(1);
            if (edge_vals && $urandom_range(1)) begin
               bt.sig = 8'sh7F;
               bt.chan = 4'd14;
               bt.lat = 31'(900000000);
               bt.lon = 32'(1800000000);
               bt.alt = 21'(1000000);
               bt.tms = 32'hFFFF_FFFF;
            end else if (edge_vals) begin
               bt.sig = -8'sd128;
               bt.chan = 4'd1;
               bt.lat = 31'(-900000000);
               bt.lon = 32'(-1800000000);
               bt.alt = 21'(-100000);
               bt.tms = '0;
            end else begin
               bt.sig = ($urandom_range(9) == 0) ? 8'sd0 : 8'($urandom);
               bt.chan = 4'($urandom_range(14, 1));
               bt.lat = 31'($urandom_range(1800000000) - 900000000);
               bt.lon = 32'($urandom_range(32'd3600000000)) - 32'd1800000000;
               bt.alt = 21'(int'($urandom_range(1100000)) - 100000);
               bt.tms = $urandom;
            end
         end else begin
            bt.mgmt = $urandom_range(1);
            bt.sig  = 8'($urandom);
            bt.chan = 4'($urandom);
            bt.fix  = $urandom_range(1);
            bt.lat  = 31'($urandom);
            bt.lon  = $urandom;
            bt.alt  = 21'($urandom);
            bt.tms  = $urandom;
         end
         send_beat(bt);
      end
   endtask

   // Withdraws the last beat so that it is not taken twice, then waits.
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
   endtask

   // Builds the fixed 36-byte head of a management frame: subtype in the top
   // nibble of byte 0, BSSID in bytes 16 to 21 and the privacy bit in byte 34.
   task automatic build_head(input logic [3:0] subtype, input logic [47:0] bssid,
                             input bit privacy);
      frame_bytes.delete();
      frame_bytes.push_back({subtype, 4'($urandom)});
      for (int i = 1; i < 16; i++) frame_bytes.push_back(8'($urandom));
      for (int i = 5; i >= 0; i--) frame_bytes.push_back(bssid[8*i +: 8]);
      for (int i = 22; i < 34; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({3'($urandom), privacy, 4'($urandom)});
      frame_bytes.push_back(8'($urandom));
   endtask

   // RSN element with one pairwise suite and one AKM suite, SAE or PSK.
   task automatic add_rsn(input bit sae);
      logic [7:0] body[$];
      body = '{8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04, 8'h01, 8'h00,
               8'h00, 8'h0F, 8'hAC, 8'h04, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC,
               sae ? 8'h08 : 8'h02};
      frame_bytes.push_back(bpat_pkg::EID_RSN);
      frame_bytes.push_back(8'(body.size()));
      foreach (body[i]) frame_bytes.push_back(body[i]);
   endtask

   // Vendor element; with wpa set it starts 00-50, else a random OUI or a
   // body too short to count.
   task automatic add_vendor(input bit wpa);
      int n;
      n = wpa ? $urandom_range(8, 4) : $urandom_range(6);
      frame_bytes.push_back(bpat_pkg::EID_VENDOR);
      frame_bytes.push_back(8'(n));
      for (int i = 0; i < n; i++) begin
         if (i == 0 && (wpa || n < 4)) frame_bytes.push_back(8'h00);
         else if (i == 1 && (wpa || n < 4)) frame_bytes.push_back(8'h50);
         else frame_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic add_misc_element();
      int n;
      n = $urandom_range(12);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'(n));
      for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic add_fcs();
      repeat (4) frame_bytes.push_back(8'($urandom));
   endtask

   // Directed frames: every status but a full table, each auth class, the element corner cases,
   // missing bytes, a one-byte frame and a frame long enough to saturate.
   task automatic test_directed();
      // Not management, then management but shorter than 36 bytes.
      build_head(4'h8, mac_pool[0], 0); add_fcs();
      send_frame(frame_bytes.size(), 0, 0);
      frame_bytes = '{8'h80, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
      send_frame(35, 1, 0);
      // Wrong subtype.
      build_head(4'h4, mac_pool[1], 0); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      // Open beacon, then a WEP probe response.
      build_head(4'h8, mac_pool[2], 0); add_misc_element(); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      build_head(4'h5, mac_pool[3], 1); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      // WPA through the vendor element, then WPA2 and WPA3 through RSN.
      build_head(4'h8, mac_pool[4], 1); add_vendor(1); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      build_head(4'h8, mac_pool[5], 1); add_rsn(0); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      build_head(4'h8, mac_pool[6], 1); add_rsn(1); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      // A vendor element after RSN does not downgrade; a later RSN overrides.
      build_head(4'h8, mac_pool[7], 1); add_rsn(1); add_vendor(1); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      build_head(4'h8, mac_pool[8], 0); add_vendor(1); add_rsn(1); add_rsn(0); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      // An element that runs past the tag region stops the walk.
      build_head(4'h8, mac_pool[9], 0); add_misc_element(); add_rsn(1); add_fcs();
      send_frame(frame_bytes.size() - 6, 1, 0);
      // Same BSSID again, so the entry is found rather than inserted.
      build_head(4'h8, mac_pool[2], 0); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
      // One-byte frame: the BSSID bytes never arrive and count as zero.
      frame_bytes = '{8'h80};
      send_frame(100, 1, 0);
      // Frame longer than 4095 bytes, so the byte counter saturates.
      build_head(4'h5, mac_pool[10], 0);
      while (frame_bytes.size() < 4100) frame_bytes.push_back(8'($urandom));
      send_frame(4095, 1, 0);
   endtask

   // Random frames: mostly well-formed beacons with random elements, the
   // rest noise with random lengths, side data and per-beat lengths.
   task automatic test_random_frames(input int byte_budget);
      int stop_at;
      int pick;
      int n;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            build_head($urandom_range(1) ? 4'h8 : 4'h5,
                       mac_pool[$urandom_range(47)], $urandom_range(1));
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) begin
               pick = $urandom_range(4);
               case (pick)
                  0: add_rsn(0);
                  1: add_rsn(1);
                  2: add_vendor(1);
                  3: add_vendor(0);
                  default: add_misc_element();
               endcase
            end
            add_fcs();
            if ($urandom_range(9) == 0)
               send_frame(frame_bytes.size() + $urandom_range(8) - 4, 1, 0);
            else
               send_frame(frame_bytes.size(), 1, 0);
         end else begin
            frame_bytes.delete();
            n = $urandom_range(60, 1);
            for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
            send_frame($urandom_range(1) ? n : $urandom_range(4095), $urandom_range(1),
                       $urandom_range(1));
         end
      end
   endtask

   // The receiver holds off for a long stretch while frames keep coming, so
   // the block has to stall its input; then the sender waits for every answer.
   task automatic test_result_backpressure();
      recv_hold_left = 900;
      test_random_frames(200);
      wait_results_drained();
   endtask

   // Fills the table with fresh BSSIDs in minimal frames, then offers more
   // new ones, which are dropped, and a known one, which is still recorded.
   task automatic test_table_full();
      int extra;
      extra = 0;
      while (ap_fill < bpat_pkg::MAX_ENTRIES || extra < 3) begin
         if (ap_fill >= bpat_pkg::MAX_ENTRIES) extra++;
         fresh_mac++;
         build_head(4'h8, fresh_mac, $urandom_range(1));
         send_frame(36, 1, 0);
      end
      build_head(4'h5, mac_pool[3], 0); add_fcs();
      send_frame(frame_bytes.size(), 1, 0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // First phase: the sender idles less than the receiver.
      send_idle_pct = 23;
      recv_idle_pct = 59;
      test_directed();
      test_random_frames(400);
      wait_results_drained();

      // Second phase: the other way round, with the long receiver hold-off.
      send_idle_pct = 59;
      recv_idle_pct = 23;
      test_result_backpressure();
      test_random_frames(300);
      wait_results_drained();

      // Last phase: neither side idles; the table is driven to full.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_table_full();
      test_random_frames(250);

      wait_results_drained();
      // A stray beat would show up within one table search.
      repeat (bpat_pkg::MAX_ENTRIES + 40) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bpat_pkg.sv
sv/bpat_parser.sv
sv/bpat_cell.sv
sv/beacon_parse_ap_table.sv
sim/tb_beacon_parse_ap_table.sv
